// ===== design/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Scanner state, result entry layout, status codes and character codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_RES = 6;
    localparam int CNT_W   = 3;

    typedef enum logic [2:0] {
        MODE_LIT     = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX     = 3'd2,
        MODE_WAIT_BS = 3'd3,
        MODE_WAIT_U  = 3'd4,
        MODE_LOWHEX  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        RULE_NONE   = 2'd0,
        RULE_MIN_A0 = 2'd1,
        RULE_MIN_90 = 2'd2,
        RULE_MAX_8F = 2'd3
    } rule_t;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_BAD_ESC = 3'd2,
        ST_CTRL    = 3'd3,
        ST_BAD_ENC = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_BYTE   = 2'd1,
        ACT_CP     = 2'd2,
        ACT_STATUS = 2'd3
    } act_t;

    // All-zero is the reset state
    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex;
        logic [1:0]  hex_cnt;
        logic [9:0]  pend;
        logic [1:0]  cont;
        rule_t       rule;
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        status_t    stat;
    } res_t;

    typedef struct packed {
        act_t       act;
        logic [7:0] data;
        status_t    stat;
        mode_t      mode;
        logic [1:0] cont;
        rule_t      rule;
    } step_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

endpackage

// ===== design/jsu_step.sv =====
// ----------------------------------------------------------------------------
// jsu_step: one-byte decode step
// Given the scanner state and one input byte, produces the next state and
// the list of up to six result entries caused by that byte.
// ----------------------------------------------------------------------------
module jsu_step (
    input  jsu_pkg::state_t                          st,
    input  logic [7:0]                               in_byte,
    output jsu_pkg::state_t                          st_next,
    output jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0]     res,
    output logic [jsu_pkg::CNT_W-1:0]                res_cnt
);

    function automatic jsu_pkg::res_t dat(input logic [7:0] b);
        jsu_pkg::res_t r;
        r.data  = b;
        r.valid = 1'b1;
        r.stat  = jsu_pkg::ST_DATA;
        return r;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic jsu_pkg::step_t lit_step(input logic [7:0] b,
                                                input logic [1:0] cont,
                                                input jsu_pkg::rule_t rule);
        jsu_pkg::step_t s;
        logic ok;
        s.act  = jsu_pkg::ACT_NONE;
        s.data = b;
        s.stat = jsu_pkg::ST_DATA;
        s.mode = jsu_pkg::MODE_LIT;
        s.cont = cont;
        s.rule = rule;
        ok     = 1'b0;
        if (cont != 2'd0)
        begin
            ok = (b[7:6] == 2'b10)
                && !(rule == jsu_pkg::RULE_MIN_A0 && b < 8'hA0)
                && !(rule == jsu_pkg::RULE_MIN_90 && b < 8'h90)
                && !(rule == jsu_pkg::RULE_MAX_8F && b > 8'h8F);
            if (ok)
            begin
                s.act  = jsu_pkg::ACT_BYTE;
                s.cont = cont - 2'd1;
                s.rule = jsu_pkg::RULE_NONE;
            end
            else
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_BAD_ENC;
            end
        end
        else
        begin
            priority if (b == jsu_pkg::CH_QUOTE)
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_CLOSED;
            end
            else if (b == jsu_pkg::CH_BSLASH)
                s.mode = jsu_pkg::MODE_ESC;
            else if (b < 8'h20)
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_CTRL;
            end
            else if (b < 8'h80)
                s.act = jsu_pkg::ACT_BYTE;
            else if (b < 8'hC2)
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_BAD_ENC;
            end
            else if (b < 8'hE0)
            begin
                s.act  = jsu_pkg::ACT_BYTE;
                s.cont = 2'd1;
            end
            else if (b < 8'hF0)
            begin
                s.act  = jsu_pkg::ACT_BYTE;
                s.cont = 2'd2;
                s.rule = (b == 8'hE0) ? jsu_pkg::RULE_MIN_A0 : jsu_pkg::RULE_NONE;
            end
            else if (b <= 8'hF4)
            begin
                s.act  = jsu_pkg::ACT_BYTE;
                s.cont = 2'd3;
                s.rule = (b == 8'hF0) ? jsu_pkg::RULE_MIN_90 :
                         (b == 8'hF4) ? jsu_pkg::RULE_MAX_8F : jsu_pkg::RULE_NONE;
            end
            else
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_BAD_ENC;
            end
        end
        return s;
    endfunction

    function automatic jsu_pkg::step_t esc_step(input logic [7:0] b);
        jsu_pkg::step_t s;
        s.act  = jsu_pkg::ACT_BYTE;
        s.data = b;
        s.stat = jsu_pkg::ST_DATA;
        s.mode = jsu_pkg::MODE_LIT;
        s.cont = 2'd0;
        s.rule = jsu_pkg::RULE_NONE;
        unique case (b)
            jsu_pkg::CH_LC_U:
            begin
                s.act  = jsu_pkg::ACT_NONE;
                s.mode = jsu_pkg::MODE_HEX;
            end
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: s.data = b;
            jsu_pkg::CH_LC_B: s.data = 8'h08;
            jsu_pkg::CH_LC_F: s.data = 8'h0C;
            jsu_pkg::CH_LC_N: s.data = 8'h0A;
            jsu_pkg::CH_LC_R: s.data = 8'h0D;
            jsu_pkg::CH_LC_T: s.data = 8'h09;
            default:
            begin
                s.act  = jsu_pkg::ACT_STATUS;
                s.stat = jsu_pkg::ST_BAD_ESC;
            end
        endcase
        return s;
    endfunction

    jsu_pkg::step_t             sub;
    logic                       use_sub;
    logic                       pre;
    jsu_pkg::act_t              act;
    logic [20:0]                val;
    jsu_pkg::status_t           stat;
    logic [4:0]                 hd;
    logic [15:0]                hexn;
    logic [15:0]                pend_cp;
    jsu_pkg::res_t [2:0]        pre_res;
    jsu_pkg::res_t [3:0]        main_res;
    logic [2:0]                 main_n;
    jsu_pkg::res_t              blank;

    assign hd   = hex_digit(in_byte);
    assign hexn = {st.hex[11:0], hd[3:0]};

    // Decode: pre flags the waiting high surrogate ahead of the main result
    always_comb
    begin
        st_next = st;
        pre     = 1'b0;
        act     = jsu_pkg::ACT_NONE;
        val     = 21'd0;
        stat    = jsu_pkg::ST_DATA;
        use_sub = 1'b0;
        sub     = lit_step(in_byte, st.cont, st.rule);
        unique case (st.mode)
            jsu_pkg::MODE_ESC:
            begin
                use_sub = 1'b1;
                sub     = esc_step(in_byte);
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX:
            begin
                if (!hd[4])
                begin
                    pre     = (st.mode == jsu_pkg::MODE_LOWHEX);
                    act     = jsu_pkg::ACT_STATUS;
                    stat    = jsu_pkg::ST_BAD_ESC;
                    st_next = '0;
                end
                else if (st.hex_cnt != 2'd3)
                begin
                    st_next.hex     = hexn;
                    st_next.hex_cnt = st.hex_cnt + 2'd1;
                end
                else if (st.mode == jsu_pkg::MODE_LOWHEX && hexn[15:10] == jsu_pkg::LO_SURR_TAG)
                begin
                    act     = jsu_pkg::ACT_CP;
                    val     = jsu_pkg::SUPP_BASE + {1'b0, st.pend, hexn[9:0]};
                    st_next = '0;
                end
                else
                begin
                    // complete first value; a non-low second value flushes the pending one
                    pre             = (st.mode == jsu_pkg::MODE_LOWHEX);
                    st_next.hex     = 16'd0;
                    st_next.hex_cnt = 2'd0;
                    st_next.pend    = 10'd0;
                    if (hexn[15:10] == jsu_pkg::HI_SURR_TAG)
                    begin
                        st_next.pend = hexn[9:0];
                        st_next.mode = jsu_pkg::MODE_WAIT_BS;
                    end
                    else
                    begin
                        act          = jsu_pkg::ACT_CP;
                        val          = {5'd0, hexn};
                        st_next.mode = jsu_pkg::MODE_LIT;
                    end
                end
            end
            jsu_pkg::MODE_WAIT_BS:
            begin
                if (in_byte == jsu_pkg::CH_BSLASH)
                    st_next.mode = jsu_pkg::MODE_WAIT_U;
                else
                begin
                    pre          = 1'b1;
                    st_next.pend = 10'd0;
                    use_sub      = 1'b1;
                end
            end
            jsu_pkg::MODE_WAIT_U:
            begin
                if (in_byte == jsu_pkg::CH_LC_U)
                begin
                    st_next.mode    = jsu_pkg::MODE_LOWHEX;
                    st_next.hex     = 16'd0;
                    st_next.hex_cnt = 2'd0;
                end
                else
                begin
                    pre          = 1'b1;
                    st_next.pend = 10'd0;
                    use_sub      = 1'b1;
                    sub          = esc_step(in_byte);
                end
            end
            default:
                use_sub = 1'b1;
        endcase

        if (use_sub)
        begin
            act  = sub.act;
            val  = {13'd0, sub.data};
            stat = sub.stat;
            if (sub.act == jsu_pkg::ACT_STATUS)
                st_next = '0;
            else
            begin
                st_next.mode = sub.mode;
                st_next.cont = sub.cont;
                st_next.rule = sub.rule;
                if (sub.mode == jsu_pkg::MODE_HEX)
                begin
                    st_next.hex     = 16'd0;
                    st_next.hex_cnt = 2'd0;
                end
            end
        end
    end

    assign pend_cp = {jsu_pkg::HI_SURR_TAG, st.pend};
    assign blank   = '0;

    always_comb
    begin
        pre_res[0] = dat({4'hE, pend_cp[15:12]});
        pre_res[1] = dat({2'b10, pend_cp[11:6]});
        pre_res[2] = dat({2'b10, pend_cp[5:0]});
    end

    // Build the main result list: one byte, one status, or a UTF-8 sequence
    always_comb
    begin
        main_res = '0;
        main_n   = 3'd0;
        unique case (act)
            jsu_pkg::ACT_BYTE:
            begin
                main_res[0] = dat(val[7:0]);
                main_n      = 3'd1;
            end
            jsu_pkg::ACT_STATUS:
            begin
                main_res[0].stat = stat;
                main_n           = 3'd1;
            end
            jsu_pkg::ACT_CP:
            begin
                priority if (val[20:7] == 14'd0)
                begin
                    main_res[0] = dat(val[7:0]);
                    main_n      = 3'd1;
                end
                else if (val[20:11] == 10'd0)
                begin
                    main_res[0] = dat({3'b110, val[10:6]});
                    main_res[1] = dat({2'b10, val[5:0]});
                    main_n      = 3'd2;
                end
                else if (val[20:16] == 5'd0)
                begin
                    main_res[0] = dat({4'hE, val[15:12]});
                    main_res[1] = dat({2'b10, val[11:6]});
                    main_res[2] = dat({2'b10, val[5:0]});
                    main_n      = 3'd3;
                end
                else
                begin
                    main_res[0] = dat({5'b11110, val[20:18]});
                    main_res[1] = dat({2'b10, val[17:12]});
                    main_res[2] = dat({2'b10, val[11:6]});
                    main_res[3] = dat({2'b10, val[5:0]});
                    main_n      = 3'd4;
                end
            end
            default:
                main_n = 3'd0;
        endcase
    end

    // Pending high surrogate bytes go first; a flushed pair never needs a fourth main byte
    always_comb
    begin
        if (pre)
            res = {main_res[2:0], pre_res};
        else
            res = {blank, blank, main_res};
        res_cnt = main_n + (pre ? 3'd3 : 3'd0);
    end

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 checks
// The accepted byte is registered in the input stage and decoded into the
// six-entry result queue once the queue is free. One item per cycle while each
// item gives at most one result and out_ready is high; an item with several
// results stalls the input until its last result is being taken.
// Reset clears the scanner to literal mode and empties both stages.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] status,
    output logic       last
);

    logic                                   in_full_reg;
    logic [7:0]                             in_byte_reg;
    jsu_pkg::state_t                        state_reg;
    jsu_pkg::state_t                        state_next;
    jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0]   res_reg;
    jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0]   res_next;
    logic [jsu_pkg::CNT_W-1:0]              cnt_reg;
    logic [jsu_pkg::CNT_W-1:0]              cnt_next;
    logic                                   buf_free;
    logic                                   adv;
    logic                                   pop;

    jsu_step u_step (
        .st      (state_reg),
        .in_byte (in_byte_reg),
        .st_next (state_next),
        .res     (res_next),
        .res_cnt (cnt_next)
    );

    assign pop      = out_valid && out_ready;
    assign buf_free = (cnt_reg == '0) || (cnt_reg == jsu_pkg::CNT_W'(1) && out_ready);
    assign adv      = in_full_reg && buf_free;
    assign in_ready = !in_full_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (adv)
                in_full_reg <= 1'b0;
            if (adv)
            begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
            end
            else if (pop)
                cnt_reg <= cnt_reg - jsu_pkg::CNT_W'(1);
        end
    end

    // Payload: load the whole list for a new item, else shift toward the head
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
        if (adv)
            res_reg <= res_next;
        else if (pop)
        begin
            for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++)
                res_reg[i] <= res_reg[i + 1];
        end
    end

    assign out_valid  = (cnt_reg != '0);
    assign out_byte   = res_reg[0].data;
    assign byte_valid = res_reg[0].valid;
    assign status     = res_reg[0].stat;
    assign last       = (cnt_reg == jsu_pkg::CNT_W'(1));

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= jsu_pkg::CNT_W'(jsu_pkg::MAX_RES))
        else $error("result count out of range");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last)
        else $error("status result not last of its item");

    a_status_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> state_reg == '0)
        else $error("scanner not back in start state after status");

    a_data_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid == (status == jsu_pkg::ST_DATA)))
        else $error("data flag disagrees with status code");

endmodule
